// ===== hdl/fmsts_pkg.sv =====
// Package for the FM step trigger sequencer.
// Shared types and fixed-point constants; no dependencies.
package fmsts_pkg;

   localparam int unsigned BASE_W     = 24;
   localparam int unsigned MASK_W     = 16;
   localparam int unsigned DEPTH_W    = 16;
   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned STEP_W     = 4;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 24;
   localparam int unsigned PROD_W     = 32;  // |m| * d, Q5.27
   localparam int unsigned WORK_W     = 33;  // accumulator / remainder
   localparam int unsigned ALU_W      = 34;  // shared adder incl. carry out
   localparam int unsigned INCR_W     = 30;  // widest phase increment
   localparam int unsigned FRAC_SHIFT = 27;
   localparam int unsigned ITERS      = BASE_W;
   localparam int unsigned CNT_W      = $clog2(ITERS);

   localparam logic [BASE_W-1:0] BASE_RESET      = BASE_W'(350);
   localparam logic [STEP_W-1:0] LAST_STEP_RESET = STEP_W'(15);

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_MASK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_INC  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FM_DEPTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FM_ENABLE = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROD,
      ST_ITER,
      ST_FINISH
   } state_type;

endpackage

// ===== hdl/fm_step_trigger_sequencer_unit.sv =====
// FM step trigger sequencer, top level.
// Depends on fmsts_pkg; iterative add/subtract unit for FM scaling.
//
// Use: one request per audio sample on req_ (valid/ready) carries the signed
// Q1.15 modulation sample. One response per request on rsp_ (valid/ready)
// gives the step taken from the top four phase bits before the phase
// advances, and a trigger flag when the step changed and its mask bit is set.
// Registers are written through csr_ (write enable, index, data); the user must
// write them only while idle, which the block itself does not enforce.
// Flow: with FM off or a zero sample an accepted request goes straight to the
// finish state. Otherwise the product state forms |m|*d, then the iterate
// state runs a shared 33-bit adder over 24 bits, one bit per cycle, doing
// either a shift-add multiply (positive sample) or a restoring divide
// (negative sample), then the finish state registers the response and
// advances the phase. req_ready is high only in the idle state.
// The response sits in an output register, so the next request is accepted
// and worked on while the previous response waits; a stalled receiver holds
// the block in its final cycle once the next result is ready.
// Reset (synchronous) restores register defaults, phase 0 and last step 15.
module fm_step_trigger_sequencer_unit
   import fmsts_pkg::*;
#(
   parameter int unsigned PHASE_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [SAMPLE_W-1:0]   req_fm_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_trigger,
   output logic [STEP_W-1:0]            rsp_step_index,
   input  logic                         csr_wr_en,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   state_type               state_ff, state_in;
   logic [MASK_W-1:0]       step_mask_ff, step_mask_in;
   logic [BASE_W-1:0]       base_inc_ff, base_inc_in;
   logic [DEPTH_W-1:0]      fm_depth_ff, fm_depth_in;
   logic                    fm_en_ff, fm_en_in;
   logic [PHASE_BITS-1:0]   phase_ff, phase_in;
   logic [STEP_W-1:0]       last_step_ff, last_step_in;
   logic                    neg_ff, neg_in;
   logic                    bypass_ff, bypass_in;
   logic [SAMPLE_W-1:0]     mag_ff, mag_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [WORK_W-1:0]       work_ff, work_in;
   logic [BASE_W-1:0]       bsh_ff, bsh_in;
   logic [BASE_W-1:0]       quo_ff, quo_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_trigger_ff, rsp_trigger_in;
   logic [STEP_W-1:0]       rsp_step_ff, rsp_step_in;

   logic [SAMPLE_W-1:0]     sample_raw;
   logic [PROD_W-1:0]       divisor;
   logic [WORK_W-1:0]       alu_a, alu_b;
   logic                    alu_cin;
   logic [ALU_W-1:0]        alu_sum;
   logic [INCR_W-1:0]       incr;
   logic [PHASE_BITS+INCR_W-1:0] incr_ext;
   logic [STEP_W-1:0]       cur_step;

   assign sample_raw = req_fm_sample;
   assign divisor    = prod_ff + PROD_W'(64'd1 << FRAC_SHIFT);
   assign cur_step   = phase_ff[PHASE_BITS-1 -: STEP_W];
   assign incr_ext   = {{PHASE_BITS{1'b0}}, incr};

   // shared adder: add for the multiply, compare-subtract for the divide
   always_comb begin
      if (neg_ff) begin
         alu_a   = {work_ff[WORK_W-2:0], 1'b0};
         alu_b   = ~{1'b0, divisor};
         alu_cin = 1'b1;
      end else begin
         alu_a   = {1'b0, work_ff[WORK_W-2:0]};
         alu_b   = bsh_ff[0] ? {1'b0, prod_ff} : '0;
         alu_cin = 1'b0;
      end
      alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + ALU_W'(alu_cin);
   end

   always_comb begin
      priority if (bypass_ff) begin
         incr = INCR_W'(base_inc_ff);
      end else if (neg_ff) begin
         incr = INCR_W'(quo_ff);
      end else begin
         incr = INCR_W'(base_inc_ff) + INCR_W'(work_ff[PROD_W-1:FRAC_SHIFT-BASE_W]);
      end
   end

   always_comb begin
      state_in       = state_ff;
      step_mask_in   = step_mask_ff;
      base_inc_in    = base_inc_ff;
      fm_depth_in    = fm_depth_ff;
      fm_en_in       = fm_en_ff;
      phase_in       = phase_ff;
      last_step_in   = last_step_ff;
      neg_in         = neg_ff;
      bypass_in      = bypass_ff;
      mag_in         = mag_ff;
      prod_in        = prod_ff;
      work_in        = work_ff;
      bsh_in         = bsh_ff;
      quo_in         = quo_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_trigger_in = rsp_trigger_ff;
      rsp_step_in    = rsp_step_ff;
      req_ready      = 1'b0;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_STEP_MASK: step_mask_in = csr_wdata[MASK_W-1:0];
            CSR_BASE_INC:  base_inc_in  = csr_wdata[BASE_W-1:0];
            CSR_FM_DEPTH:  fm_depth_in  = csr_wdata[DEPTH_W-1:0];
            CSR_FM_ENABLE: fm_en_in     = csr_wdata[0];
            default:       ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               neg_in    = sample_raw[SAMPLE_W-1];
               mag_in    = sample_raw[SAMPLE_W-1] ? SAMPLE_W'(-sample_raw) : sample_raw;
               bypass_in = !fm_en_ff || (sample_raw == '0);
               state_in  = (!fm_en_ff || (sample_raw == '0)) ? ST_FINISH : ST_PROD;
            end
         end
         ST_PROD: begin
            prod_in  = PROD_W'(mag_ff) * PROD_W'(fm_depth_ff);
            work_in  = neg_ff ? WORK_W'({base_inc_ff, 3'b000}) : '0;
            bsh_in   = base_inc_ff;
            quo_in   = '0;
            cnt_in   = '0;
            state_in = ST_ITER;
         end
         ST_ITER: begin
            if (neg_ff) begin
               work_in = alu_sum[ALU_W-1] ? alu_sum[WORK_W-1:0] : alu_a;
               quo_in  = {quo_ff[BASE_W-2:0], alu_sum[ALU_W-1]};
            end else begin
               work_in = {1'b0, alu_sum[WORK_W-1:1]};
               bsh_in  = {1'b0, bsh_ff[BASE_W-1:1]};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ITERS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_step_in    = cur_step;
               rsp_trigger_in = (cur_step != last_step_ff) && step_mask_ff[cur_step];
               last_step_in   = cur_step;
               phase_in       = phase_ff + incr_ext[PHASE_BITS-1:0];
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_mask_ff <= '0;
         base_inc_ff  <= BASE_RESET;
         fm_depth_ff  <= '0;
         fm_en_ff     <= 1'b0;
         phase_ff     <= '0;
         last_step_ff <= LAST_STEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_mask_ff <= step_mask_in;
         base_inc_ff  <= base_inc_in;
         fm_depth_ff  <= fm_depth_in;
         fm_en_ff     <= fm_en_in;
         phase_ff     <= phase_in;
         last_step_ff <= last_step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff         <= neg_in;
      bypass_ff      <= bypass_in;
      mag_ff         <= mag_in;
      prod_ff        <= prod_in;
      work_ff        <= work_in;
      bsh_ff         <= bsh_in;
      quo_ff         <= quo_in;
      cnt_ff         <= cnt_in;
      rsp_trigger_ff <= rsp_trigger_in;
      rsp_step_ff    <= rsp_step_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_trigger    = rsp_trigger_ff;
   assign rsp_step_index = rsp_step_ff;

endmodule

// ===== hdl/fmsts_checker.sv =====
// Port-level checker for the FM step trigger sequencer.
// Depends on fmsts_pkg; bound to fm_step_trigger_sequencer_unit.
module fmsts_port_checker
   import fmsts_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_trigger,
   input logic [STEP_W-1:0]          rsp_step_index
);

   // idle with nothing pending right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("not idle after reset");

   // one request at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // a response never appears without a request in flight
   a_rsp_needs_req: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && req_ready && !(req_valid && req_ready) |=> !rsp_valid)
      else $error("response without request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_trigger)
         && $stable(rsp_step_index))
      else $error("stalled response changed");

endmodule

bind fm_step_trigger_sequencer_unit fmsts_port_checker u_fmsts_port_checker (.*);

// ===== test/fmsts_checker.sv =====
// Checker for the FM step trigger sequencer: tracks register writes, predicts
// the step and trigger of every accepted request and compares the responses.
// Depends on fmsts_pkg.
module fmsts_checker
   import fmsts_pkg::*;
#(
   parameter int unsigned PHASE_BITS = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_fm_sample,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic                       rsp_trigger,
   input  logic [STEP_W-1:0]          rsp_step_index,
   input  logic                       csr_wr_en,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata,
   output int                         fail_count,
   output int                         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic              trigger;
      logic [STEP_W-1:0] step_index;
   } step_event_type;

   logic [MASK_W-1:0]     mask_q;
   logic [BASE_W-1:0]     base_q;
   logic [DEPTH_W-1:0]    depth_q;
   logic                  fm_on_q;
   logic [PHASE_BITS-1:0] phase_acc;
   logic [STEP_W-1:0]     prev_step;
   step_event_type        step_events[$];
   int                    fails = 0;
   int                    outstanding = 0;

   assign fail_count = fails;
   assign pending    = outstanding;

   // per-sample phase increment, FM scaling in Q5.27
   function automatic logic [63:0] scaled_increment(input logic [SAMPLE_W-1:0] sample);
      logic [63:0] base64;
      logic [63:0] mag;
      logic [63:0] prod;
      base64 = 64'(base_q);
      if (!fm_on_q || sample == '0)
         return base64;
      mag  = sample[SAMPLE_W-1] ? 64'h10000 - 64'(sample) : 64'(sample);
      prod = mag * 64'(depth_q);
      if (!sample[SAMPLE_W-1])
         return base64 + ((base64 * prod) >> FRAC_SHIFT);
      return (base64 << FRAC_SHIFT) / ((64'd1 << FRAC_SHIFT) + prod);
   endfunction

   always @(posedge clock) begin
      step_event_type    want;
      logic [STEP_W-1:0] step;
      logic              trig;
      logic [63:0]       incr;
      int                errs;
      errs = 0;
      if (reset) begin
         mask_q    = '0;
         base_q    = BASE_RESET;
         depth_q   = '0;
         fm_on_q   = 1'b0;
         phase_acc = '0;
         prev_step = LAST_STEP_RESET;
         step_events.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (step_events.size() == 0) begin
               $error("response with no request outstanding: trigger %0d, step_index %0d",
                      rsp_trigger, rsp_step_index);
               errs++;
            end else begin
               want = step_events.pop_front();
               if (rsp_trigger !== want.trigger) begin
                  $error("trigger mismatch: expected %0d, got %0d", want.trigger, rsp_trigger);
                  errs++;
               end
               if (rsp_step_index !== want.step_index) begin
                  $error("step_index mismatch: expected %0d, got %0d",
                         want.step_index, rsp_step_index);
                  errs++;
               end
            end
         end
         if (req_valid && req_ready) begin
            step = phase_acc[PHASE_BITS-1 -: STEP_W];
            trig = 1'b0;
            if (step != prev_step) begin
               trig      = mask_q[step];
               prev_step = step;
            end
            incr      = scaled_increment(req_fm_sample);
            phase_acc = phase_acc + PHASE_BITS'(incr);
            step_events.push_back('{trigger: trig, step_index: step});
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_STEP_MASK: mask_q  = csr_wdata[MASK_W-1:0];
               CSR_BASE_INC:  base_q  = csr_wdata[BASE_W-1:0];
               CSR_FM_DEPTH:  depth_q = csr_wdata[DEPTH_W-1:0];
               CSR_FM_ENABLE: fm_on_q = csr_wdata[0];
               default: ;
            endcase
         end
      end
      fails       <= fails + errs;
      outstanding <= step_events.size();
   end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the FM step trigger sequencer: clock, reset, request
// stimulus, register programming and receiver stalls, plus the verdict.
// Depends on fmsts_pkg, fm_step_trigger_sequencer_unit and fmsts_checker.
module tb_top
   import fmsts_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_fm_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_trigger;
   logic [STEP_W-1:0]          rsp_step_index;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;
   int                         fail_count;
   int                         pending;
   logic                       quiet_tail = 1'b0;
   int                         rsp_hold = 0;

   fm_step_trigger_sequencer_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_fm_sample  (req_fm_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_trigger    (rsp_trigger),
      .rsp_step_index (rsp_step_index),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   fmsts_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_fm_sample  (req_fm_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_trigger    (rsp_trigger),
      .rsp_step_index (rsp_step_index),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("fm_step_trigger_sequencer_unit test failed");
      $finish;
   end

   // receiver drops rsp_ready in random bursts
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
         rsp_hold  <= int'($urandom_range(0, 14));
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      req_valid     <= 1'b1;
      req_fm_sample <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // hold off until every response is back, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (32) @(posedge clock);
   endtask

   task automatic program_regs(input logic [CSR_DATA_W-1:0] mask_v, base_v, depth_v, en_v);
      logic [CSR_DATA_W-1:0] vals[4];
      logic [CSR_IDX_W-1:0]  idxs[4];
      vals = '{mask_v, base_v, depth_v, en_v};
      idxs = '{CSR_STEP_MASK, CSR_BASE_INC, CSR_FM_DEPTH, CSR_FM_ENABLE};
      csr_wr_en <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         csr_index <= idxs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_wide(input logic [CSR_DATA_W-1:0] top);
      case ($urandom_range(0, 3))
         0: return CSR_DATA_W'($urandom_range(0, 4095));
         1: return CSR_DATA_W'($urandom_range(0, 24'h3FFFF));
         2: return CSR_DATA_W'($urandom());
         default: return $urandom_range(0, 1) ? top : '0;
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      logic [SAMPLE_W-1:0] corners[5];
      logic [SAMPLE_W-1:0] mag;
      corners = '{16'h0000, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF};
      case ($urandom_range(0, 5))
         0: return corners[$urandom_range(0, 4)];
         1: begin
            mag = SAMPLE_W'($urandom_range(0, 255));
            return $urandom_range(0, 1) ? -mag : mag;
         end
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   initial begin
      logic [SAMPLE_W-1:0]   probe_max[9];
      logic [CSR_DATA_W-1:0] junk;
      probe_max = '{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h0000,
                    16'h4000, 16'hC000, 16'h5555, 16'hAAAA};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // defaults after reset: FM off, empty mask
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      drain();

      // full mask with junk above it, largest increment and depth
      program_regs(24'hFF_FFFF, 24'hFF_FFFF, 24'h12_FFFF, 24'hFF_FFFF);
      foreach (probe_max[i]) send_sample(probe_max[i]);
      drain();

      // one step per sample, FM off
      program_regs(24'h00_A5A5, 24'h10_0000, 24'h00_1000, 24'hFF_FFFE);
      for (int i = 0; i < 6; i++) send_sample(probe_max[i]);
      drain();

      // tiny increment: the step stays put
      program_regs(24'h00_FFFF, 24'h00_0001, 24'h00_0000, 24'h00_0001);
      for (int i = 0; i < 4; i++) send_sample(probe_max[i]);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         quiet_tail <= (ph == 7);
         junk = CSR_DATA_W'($urandom());
         case (ph)
            0: program_regs(24'h00_FFFF, 24'hFF_FFFF, 24'h00_FFFF, 24'h00_0001);
            1: program_regs(24'h00_0000, 24'h00_0000, 24'h00_0000, 24'h00_0001);
            default: program_regs(CSR_DATA_W'($urandom()), pick_wide(24'hFF_FFFF),
                                  pick_wide(24'h00_FFFF),
                                  {junk[CSR_DATA_W-1:1], ($urandom_range(0, 3) != 0)});
         endcase
         for (int n = 0; n < 230; n++) begin
            send_sample(pick_sample());
            if ($urandom_range(0, 149) == 0) drain();
         end
         drain();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("fm_step_trigger_sequencer_unit test passed");
      end else begin
         $display("fm_step_trigger_sequencer_unit test failed");
      end
      $finish;
   end

endmodule
